### design/s2cd_pkg.sv
package s2cd_pkg;

    localparam int unsigned SEC_PER_MIN   = 60;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOUR_PER_DAY  = 24;

    // exact reciprocals for 32-bit unsigned operands
    localparam logic [31:0] RECIP_60       = 32'h8888_8889;
    localparam int unsigned RECIP_60_SHIFT = 37;
    localparam logic [31:0] RECIP_3        = 32'hAAAA_AAAB;
    localparam int unsigned RECIP_3_SHIFT  = 33;

    localparam int unsigned BASE_YEAR    = 1950;
    localparam int unsigned COMMON_DAYS  = 365;
    localparam int unsigned LEAP_DAYS    = 366;
    localparam int unsigned FEB_LEAP     = 29;
    localparam int unsigned FEB_COMMON   = 28;

    // four-year cycles counted from the leap year two years before the base year
    localparam int unsigned CYCLE_DAYS      = 3 * COMMON_DAYS + LEAP_DAYS;
    localparam int unsigned CYCLE_BASE_YEAR = BASE_YEAR - 2;
    localparam int unsigned EPOCH_OFFSET    = LEAP_DAYS + COMMON_DAYS;
    localparam logic [15:0] RECIP_CYCLE     = 16'd45934;
    localparam int unsigned RECIP_CYCLE_SHIFT = 26;

    localparam logic [8:0] MONTH_START_COMMON [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
    } t_tod;

    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        base = MONTH_START_COMMON[mon];
        if (leap && (mon >= 4'd2)) begin
            base = base + 9'(FEB_LEAP - FEB_COMMON);
        end
        return base;
    endfunction

endpackage

### design/s2cd_time_split.sv
module s2cd_time_split
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_secs,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_days,
    output t_tod        o_tod
);

    logic        r_a_v, r_b_v, r_c_v, r_d_v;
    logic        w_a_rdy, w_b_rdy, w_c_rdy, w_d_rdy;

    logic [31:0] r_a_t;
    logic [63:0] r_a_prod;
    logic [63:0] n_a_prod;

    logic [26:0] r_b_q1;
    logic [5:0]  r_b_sec;
    logic [63:0] r_b_prod;
    logic [26:0] n_b_q1;
    logic [31:0] w_b_q1x60;
    logic [5:0]  n_b_sec;
    logic [63:0] n_b_prod;

    logic [20:0] r_c_q2;
    logic [5:0]  r_c_sec;
    logic [5:0]  r_c_min;
    logic [63:0] r_c_prod;
    logic [20:0] n_c_q2;
    logic [26:0] w_c_q2x60;
    logic [5:0]  n_c_min;
    logic [63:0] n_c_prod;

    logic [15:0] r_d_days;
    t_tod        r_d_tod;
    logic [15:0] n_d_days;
    logic [20:0] w_d_daysx24;
    t_tod        n_d_tod;

    assign w_d_rdy = !r_d_v || i_ready;
    assign w_c_rdy = !r_c_v || w_d_rdy;
    assign w_b_rdy = !r_b_v || w_c_rdy;
    assign w_a_rdy = !r_a_v || w_b_rdy;
    assign o_ready = w_a_rdy;

    always_comb begin
        n_a_prod = 64'(i_secs) * 64'(RECIP_60);

        n_b_q1    = 27'(r_a_prod >> RECIP_60_SHIFT);
        w_b_q1x60 = 32'(n_b_q1) * 32'(SEC_PER_MIN);
        n_b_sec   = 6'(r_a_t - w_b_q1x60);
        n_b_prod  = 64'(n_b_q1) * 64'(RECIP_60);

        n_c_q2    = 21'(r_b_prod >> RECIP_60_SHIFT);
        w_c_q2x60 = 27'(n_c_q2) * 27'(MIN_PER_HOUR);
        n_c_min   = 6'(r_b_q1 - w_c_q2x60);
        // divide by 24 as a shift by three then a divide by three
        n_c_prod  = 64'(n_c_q2[20:3]) * 64'(RECIP_3);

        n_d_days    = 16'(r_c_prod >> RECIP_3_SHIFT);
        w_d_daysx24 = 21'(n_d_days) * 21'(HOUR_PER_DAY);
        n_d_tod.sec  = r_c_sec;
        n_d_tod.min  = r_c_min;
        n_d_tod.hour = 5'(r_c_q2 - w_d_daysx24);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (w_a_rdy) r_a_v <= i_valid;
            if (w_b_rdy) r_b_v <= r_a_v;
            if (w_c_rdy) r_c_v <= r_b_v;
            if (w_d_rdy) r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy && i_valid) begin
            r_a_t    <= i_secs;
            r_a_prod <= n_a_prod;
        end
        if (w_b_rdy && r_a_v) begin
            r_b_q1   <= n_b_q1;
            r_b_sec  <= n_b_sec;
            r_b_prod <= n_b_prod;
        end
        if (w_c_rdy && r_b_v) begin
            r_c_q2   <= n_c_q2;
            r_c_sec  <= r_b_sec;
            r_c_min  <= n_c_min;
            r_c_prod <= n_c_prod;
        end
        if (w_d_rdy && r_c_v) begin
            r_d_days <= n_d_days;
            r_d_tod  <= n_d_tod;
        end
    end

    assign o_valid = r_d_v;
    assign o_days  = r_d_days;
    assign o_tod   = r_d_tod;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tod.sec < 6'd60 && o_tod.min < 6'd60 && o_tod.hour < 5'd24))
        else $error("time of day out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_v && !w_d_rdy) |=> (r_c_v && r_d_v))
        else $error("stalled stage lost its transaction");

endmodule

### design/s2cd_year_split.sv
module s2cd_year_split
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_days,
    input  t_tod        i_tod,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [8:0]  o_doy,
    output logic        o_leap,
    output logic [11:0] o_year,
    output t_tod        o_tod
);

    logic        r_e_v, r_f_v, r_g_v;
    logic        w_e_rdy, w_f_rdy, w_g_rdy;

    logic [15:0] r_e_dp;
    logic [31:0] r_e_prod;
    t_tod        r_e_tod;
    logic [15:0] n_e_dp;
    logic [31:0] n_e_prod;

    logic [5:0]  r_f_cyc;
    logic [10:0] r_f_rem;
    t_tod        r_f_tod;
    logic [5:0]  n_f_cyc;
    logic [15:0] w_f_cyc_days;
    logic [10:0] n_f_rem;

    logic [8:0]  r_g_doy;
    logic        r_g_leap;
    logic [11:0] r_g_year;
    t_tod        r_g_tod;
    logic [1:0]  w_g_yoff;
    logic [8:0]  n_g_doy;
    logic [11:0] n_g_year;

    assign w_g_rdy = !r_g_v || i_ready;
    assign w_f_rdy = !r_f_v || w_g_rdy;
    assign w_e_rdy = !r_e_v || w_f_rdy;
    assign o_ready = w_e_rdy;

    always_comb begin
        n_e_dp   = i_days + 16'(EPOCH_OFFSET);
        n_e_prod = 32'(n_e_dp) * 32'(RECIP_CYCLE);

        n_f_cyc      = 6'(r_e_prod >> RECIP_CYCLE_SHIFT);
        w_f_cyc_days = 16'(n_f_cyc) * 16'(CYCLE_DAYS);
        n_f_rem      = 11'(r_e_dp - w_f_cyc_days);

        priority if (r_f_rem < 11'(LEAP_DAYS)) begin
            w_g_yoff = 2'd0;
            n_g_doy  = 9'(r_f_rem);
        end else if (r_f_rem < 11'(LEAP_DAYS + COMMON_DAYS)) begin
            w_g_yoff = 2'd1;
            n_g_doy  = 9'(r_f_rem - 11'(LEAP_DAYS));
        end else if (r_f_rem < 11'(LEAP_DAYS + 2 * COMMON_DAYS)) begin
            w_g_yoff = 2'd2;
            n_g_doy  = 9'(r_f_rem - 11'(LEAP_DAYS + COMMON_DAYS));
        end else begin
            w_g_yoff = 2'd3;
            n_g_doy  = 9'(r_f_rem - 11'(LEAP_DAYS + 2 * COMMON_DAYS));
        end
        n_g_year = 12'(CYCLE_BASE_YEAR) + {4'd0, r_f_cyc, w_g_yoff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else begin
            if (w_e_rdy) r_e_v <= i_valid;
            if (w_f_rdy) r_f_v <= r_e_v;
            if (w_g_rdy) r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_rdy && i_valid) begin
            r_e_dp   <= n_e_dp;
            r_e_prod <= n_e_prod;
            r_e_tod  <= i_tod;
        end
        if (w_f_rdy && r_e_v) begin
            r_f_cyc <= n_f_cyc;
            r_f_rem <= n_f_rem;
            r_f_tod <= r_e_tod;
        end
        if (w_g_rdy && r_f_v) begin
            r_g_doy  <= n_g_doy;
            r_g_leap <= (w_g_yoff == 2'd0);
            r_g_year <= n_g_year;
            r_g_tod  <= r_f_tod;
        end
    end

    assign o_valid = r_g_v;
    assign o_doy   = r_g_doy;
    assign o_leap  = r_g_leap;
    assign o_year  = r_g_year;
    assign o_tod   = r_g_tod;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_leap && o_doy < 9'(LEAP_DAYS)) || (!o_leap && o_doy < 9'(COMMON_DAYS))))
        else $error("day of year beyond year length");

endmodule

### design/s2cd_month_split.sv
module s2cd_month_split
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [8:0]  i_doy,
    input  logic        i_leap,
    input  logic [11:0] i_year,
    input  t_tod        i_tod,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [11:0] o_year,
    output t_tod        o_tod
);

    logic        r_h_v, r_i_v;
    logic        w_h_rdy, w_i_rdy;

    logic [8:0]  r_h_doy;
    logic        r_h_leap;
    logic [3:0]  r_h_mon;
    logic [11:0] r_h_year;
    t_tod        r_h_tod;
    logic [3:0]  n_h_mon;

    logic [4:0]  r_i_day;
    logic [3:0]  r_i_month;
    logic [11:0] r_i_year;
    t_tod        r_i_tod;
    logic [4:0]  n_i_day;

    assign w_i_rdy = !r_i_v || i_ready;
    assign w_h_rdy = !r_h_v || w_i_rdy;
    assign o_ready = w_h_rdy;

    always_comb begin
        n_h_mon = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (i_doy >= month_start(4'(m), i_leap)) begin
                n_h_mon = 4'(m);
            end
        end
        n_i_day = 5'(r_h_doy - month_start(r_h_mon, r_h_leap) + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
        end else begin
            if (w_h_rdy) r_h_v <= i_valid;
            if (w_i_rdy) r_i_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_h_rdy && i_valid) begin
            r_h_doy  <= i_doy;
            r_h_leap <= i_leap;
            r_h_mon  <= n_h_mon;
            r_h_year <= i_year;
            r_h_tod  <= i_tod;
        end
        if (w_i_rdy && r_h_v) begin
            r_i_day   <= n_i_day;
            r_i_month <= r_h_mon + 4'd1;
            r_i_year  <= r_h_year;
            r_i_tod   <= r_h_tod;
        end
    end

    assign o_valid = r_i_v;
    assign o_day   = r_i_day;
    assign o_month = r_i_month;
    assign o_year  = r_i_year;
    assign o_tod   = r_i_tod;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_day >= 5'd1 && o_month >= 4'd1 && o_month <= 4'd12))
        else $error("date field out of range");

endmodule

### design/seconds_to_calendar_date_unit.sv
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_elapsed_seconds
// result    out        o_valid / i_ready    o_second_of_minute .. o_calendar_year
//
// one transaction per cycle sustained while the result side is ready
// nine register stages: constant-reciprocal multiplies, cycle split, month compare
// reset clears the stage valid bits only
// each stage holds while the next one is full and stalled; empty stages fill in
module seconds_to_calendar_date_unit
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_elapsed_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_of_year,
    output logic [11:0] o_calendar_year
);

    logic        w_ts_valid, w_ts_ready;
    logic [15:0] w_ts_days;
    t_tod        w_ts_tod;

    logic        w_ys_valid, w_ys_ready;
    logic [8:0]  w_ys_doy;
    logic        w_ys_leap;
    logic [11:0] w_ys_year;
    t_tod        w_ys_tod;

    t_tod        w_ms_tod;

    s2cd_time_split u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_secs  (i_elapsed_seconds),
        .o_valid (w_ts_valid),
        .i_ready (w_ts_ready),
        .o_days  (w_ts_days),
        .o_tod   (w_ts_tod)
    );

    s2cd_year_split u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ts_valid),
        .o_ready (w_ts_ready),
        .i_days  (w_ts_days),
        .i_tod   (w_ts_tod),
        .o_valid (w_ys_valid),
        .i_ready (w_ys_ready),
        .o_doy   (w_ys_doy),
        .o_leap  (w_ys_leap),
        .o_year  (w_ys_year),
        .o_tod   (w_ys_tod)
    );

    s2cd_month_split u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ys_valid),
        .o_ready (w_ys_ready),
        .i_doy   (w_ys_doy),
        .i_leap  (w_ys_leap),
        .i_year  (w_ys_year),
        .i_tod   (w_ys_tod),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_day   (o_day_of_month),
        .o_month (o_month_of_year),
        .o_year  (o_calendar_year),
        .o_tod   (w_ms_tod)
    );

    assign o_second_of_minute = w_ms_tod.sec;
    assign o_minute_of_hour   = w_ms_tod.min;
    assign o_hour_of_day      = w_ms_tod.hour;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import s2cd_pkg::*;

    localparam int unsigned SECONDS_PER_DAY = SEC_PER_MIN * MIN_PER_HOUR * HOUR_PER_DAY;
    localparam int unsigned RANDOM_ITEMS    = 1750;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned MAX_PRINTS      = 100;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } date_time_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_elapsed_seconds = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [5:0]  o_second_of_minute;
    logic [5:0]  o_minute_of_hour;
    logic [4:0]  o_hour_of_day;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_of_year;
    logic [11:0] o_calendar_year;

    logic [31:0] pending_seconds [$];
    date_time_t  expected_dates [$];

    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    bit          src_steady = 1'b0;
    bit          sink_steady = 1'b0;
    int unsigned src_gap = 0;
    int unsigned sink_stall = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;

    seconds_to_calendar_date_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_elapsed_seconds  (i_elapsed_seconds),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_of_year    (o_month_of_year),
        .o_calendar_year    (o_calendar_year)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned year_length(input int unsigned year);
        return (year % 4 == 0) ? LEAP_DAYS : COMMON_DAYS;
    endfunction

    // mon counts from zero
    function automatic int unsigned month_length(input int unsigned mon, input int unsigned year);
        if (mon == 1) begin
            return (year % 4 == 0) ? FEB_LEAP : FEB_COMMON;
        end
        return MONTH_DAYS[mon];
    endfunction

    function automatic date_time_t to_date_time(input logic [31:0] stamp);
        date_time_t  r;
        int unsigned t;
        int unsigned days;
        int unsigned year;
        int unsigned mon;
        bit          done;
        t      = stamp;
        r.sec  = 6'(t % SEC_PER_MIN);
        t      = t / SEC_PER_MIN;
        r.min  = 6'(t % MIN_PER_HOUR);
        t      = t / MIN_PER_HOUR;
        r.hour = 5'(t % HOUR_PER_DAY);
        days   = t / HOUR_PER_DAY;
        year   = BASE_YEAR;
        while (days >= year_length(year)) begin
            days = days - year_length(year);
            year++;
        end
        mon  = 0;
        done = 1'b0;
        while (!done) begin
            if (days < month_length(mon, year) || mon >= 11) begin
                done = 1'b1;
            end else begin
                days = days - month_length(mon, year);
                mon++;
            end
        end
        r.day   = 5'(days + 1);
        r.month = 4'(mon + 1);
        r.year  = 12'(year);
        return r;
    endfunction

    // mon and day count from one
    function automatic longint unsigned date_to_seconds(input int unsigned year,
                                                        input int unsigned mon,
                                                        input int unsigned day);
        longint unsigned days;
        days = 0;
        for (int unsigned y = BASE_YEAR; y < year; y++) begin
            days += year_length(y);
        end
        for (int unsigned m = 1; m < mon; m++) begin
            days += month_length(m - 1, year);
        end
        days += day - 1;
        return days * SECONDS_PER_DAY;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        date_time_t want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= i_valid && o_ready;
            out_taken <= o_valid && i_ready;
            if (i_valid && o_ready) begin
                expected_dates.push_back(to_date_time(i_elapsed_seconds));
            end
            if (o_valid && i_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result transaction with nothing expected, year",
                                    o_calendar_year, 0);
                end else begin
                    want = expected_dates.pop_front();
                    if (o_second_of_minute !== want.sec)
                        report_mismatch("second_of_minute", o_second_of_minute, want.sec);
                    if (o_minute_of_hour !== want.min)
                        report_mismatch("minute_of_hour", o_minute_of_hour, want.min);
                    if (o_hour_of_day !== want.hour)
                        report_mismatch("hour_of_day", o_hour_of_day, want.hour);
                    if (o_day_of_month !== want.day)
                        report_mismatch("day_of_month", o_day_of_month, want.day);
                    if (o_month_of_year !== want.month)
                        report_mismatch("month_of_year", o_month_of_year, want.month);
                    if (o_calendar_year !== want.year)
                        report_mismatch("calendar_year", o_calendar_year, want.year);
                end
            end
        end
    end

    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (in_taken || !i_valid) begin
                if (in_taken) begin
                    if ($urandom_range(0, 99) == 0) src_steady = !src_steady;
                    src_gap = src_steady ? 0 : $urandom_range(0, 5);
                end
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_seconds.size() > 0) begin
                    i_elapsed_seconds <= pending_seconds.pop_front();
                    i_valid           <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (out_taken) begin
                if ($urandom_range(0, 99) == 0) sink_steady = !sink_steady;
                sink_stall = sink_steady ? 0 : $urandom_range(0, 5);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        longint unsigned stamp;
        longint unsigned base;
        int unsigned     kind;
        int unsigned     delta;
        int unsigned     day_index;

        // time of day extremes
        pending_seconds.push_back(32'd0);
        pending_seconds.push_back(32'd59);
        pending_seconds.push_back(32'd60);
        pending_seconds.push_back(32'd3599);
        pending_seconds.push_back(32'd3600);
        pending_seconds.push_back(32'(SECONDS_PER_DAY - 1));
        pending_seconds.push_back(32'(SECONDS_PER_DAY));
        // year and february edges, common and leap
        pending_seconds.push_back(32'(date_to_seconds(1950, 12, 31) + SECONDS_PER_DAY - 1));
        pending_seconds.push_back(32'(date_to_seconds(1951, 1, 1)));
        pending_seconds.push_back(32'(date_to_seconds(1951, 2, 28) + SECONDS_PER_DAY - 1));
        pending_seconds.push_back(32'(date_to_seconds(1951, 3, 1)));
        pending_seconds.push_back(32'(date_to_seconds(1952, 2, 28)));
        pending_seconds.push_back(32'(date_to_seconds(1952, 2, 29) + SECONDS_PER_DAY - 1));
        pending_seconds.push_back(32'(date_to_seconds(1952, 3, 1)));
        pending_seconds.push_back(32'(date_to_seconds(1952, 12, 31) + SECONDS_PER_DAY - 1));
        // century year 2000 is leap
        pending_seconds.push_back(32'(date_to_seconds(2000, 2, 29)));
        pending_seconds.push_back(32'(date_to_seconds(2000, 12, 31) + SECONDS_PER_DAY - 1));
        pending_seconds.push_back(32'(date_to_seconds(2001, 1, 1)));
        pending_seconds.push_back(32'(date_to_seconds(2086, 1, 1)));
        // full input range and bit patterns
        pending_seconds.push_back(32'hFFFF_FFFF);
        pending_seconds.push_back(32'hFFFF_FFFE);
        pending_seconds.push_back(32'h8000_0000);
        pending_seconds.push_back(32'h7FFF_FFFF);
        pending_seconds.push_back(32'hAAAA_AAAA);
        pending_seconds.push_back(32'h5555_5555);

        repeat (RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 9);
            delta = $urandom_range(0, 7200);
            stamp = {32'h0, $urandom};
            if (kind == 4 || kind == 5) begin
                // near midnight
                day_index = $urandom_range(0, 49709);
                stamp = longint'(day_index) * SECONDS_PER_DAY;
                if ($urandom_range(0, 1)) stamp += SECONDS_PER_DAY - 1 - (delta % 3600);
                else stamp += delta % 3600;
            end else if (kind == 6 || kind == 7) begin
                base = date_to_seconds($urandom_range(1950, 2085), $urandom_range(1, 12), 1);
                if ($urandom_range(0, 1) && base > delta) stamp = base - 1 - delta;
                else stamp = base + delta;
            end else if (kind == 8 || kind == 9) begin
                base = date_to_seconds($urandom_range(1951, 2086), 1, 1);
                if ($urandom_range(0, 1)) stamp = base - 1 - delta;
                else stamp = base + delta;
            end
            if (stamp > 64'hFFFF_FFFF) stamp = {32'h0, $urandom};
            pending_seconds.push_back(stamp[31:0]);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_seconds.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_dates.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
design/s2cd_pkg.sv
design/s2cd_time_split.sv
design/s2cd_year_split.sv
design/s2cd_month_split.sv
design/seconds_to_calendar_date_unit.sv
tb/tb.sv
